// File: src/tma_pkg.sv
// ----------------------------------------------------------------------------
// Trip metrics accumulator package
// Shared widths, register indexes, reset values and arithmetic unit sizes.
// ----------------------------------------------------------------------------
package tma_pkg;

   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 20;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 49;

   localparam logic [1:0] CSR_EMA_WARMUP = 2'd0;
   localparam logic [1:0] CSR_REF_EPK    = 2'd1;
   localparam logic [1:0] CSR_EMA_ALPHA  = 2'd2;
   localparam logic [1:0] CSR_BATT_CAP   = 2'd3;

   localparam logic [15:0] RST_EMA_WARMUP = 16'd240;
   localparam logic [17:0] RST_REF_EPK    = 18'd15000;
   localparam logic [15:0] RST_EMA_ALPHA  = 16'd6554;
   localparam logic [19:0] RST_BATT_CAP   = 20'd60000;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
   localparam logic [23:0] MAX24 = 24'hFF_FFFF;

endpackage

// File: src/tma_mul.sv
// ----------------------------------------------------------------------------
// Trip metrics serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle and
// stops as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module tma_mul
   import tma_pkg::*;
#(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] op_a,
   input  logic [B_W-1:0] op_b,
   output logic           busy,
   output logic           done,
   output logic [A_W-1:0] product
);

   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic [A_W-1:0] a_ff, a_in;
   logic [B_W-1:0] b_ff, b_in;
   logic [A_W-1:0] acc_ff, acc_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in = 1'b1;
         a_in   = op_a;
         b_in   = op_b;
         acc_in = '0;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[A_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[B_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy    = run_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: src/tma_div.sv
// ----------------------------------------------------------------------------
// Trip metrics serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tma_div
   import tma_pkg::*;
#(
   parameter int N_W = DIV_N_W,
   parameter int D_W = DIV_D_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [D_W-1:0]   r_ff, r_in;
   logic [D_W:0]     r_shift;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      r_shift = {r_ff, n_ff[N_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(N_W);
         n_in   = dividend;
         d_in   = divisor;
         r_in   = '0;
      end else if (run_ff) begin
         if (r_shift >= {1'b0, d_ff}) begin
            r_in = D_W'(r_shift - {1'b0, d_ff});
            n_in = {n_ff[N_W-2:0], 1'b1};
         end else begin
            r_in = r_shift[D_W-1:0];
            n_in = {n_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign busy     = run_ff;
   assign done     = done_ff;
   assign quotient = n_ff;

endmodule

// File: src/ev_trip_metrics_accumulator.sv
// ----------------------------------------------------------------------------
// EV trip metrics accumulator
// Running trip sums and derived efficiency, consumption and range figures.
// Timing: the time from request acceptance to response valid depends on the
//   multiplier operand widths and on which quotients are skipped; up to
//   eight 64-step quotients on the shared serial divider take most of it.
// Flow: one transaction at a time; a new request is taken only when the
//   sequencer is idle, while an earlier response may still be pending.
// Reset: synchronous; clears all sums, the smoothed value and the last
//   timestamp, and loads the register defaults.
// ----------------------------------------------------------------------------
module ev_trip_metrics_accumulator
   import tma_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [23:0]        req_timestamp_sec,
   input  logic [14:0]        req_speed,
   input  logic               req_coasting,
   input  logic signed [17:0] req_current,
   input  logic signed [20:0] req_energy_inst,
   input  logic [19:0]        req_ke_lost,
   input  logic [19:0]        req_energy_recovered,
   input  logic signed [14:0] req_batt_temp,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_distance_m,
   output logic [13:0]        rsp_batt_eff_pct,
   output logic [17:0]        rsp_avg_energy_per_km,
   output logic [17:0]        rsp_ema_energy_per_km,
   output logic [15:0]        rsp_regen_eff_pct,
   output logic [13:0]        rsp_coasting_pct,
   output logic [13:0]        rsp_soc_pct,
   output logic [23:0]        rsp_range_left,
   output logic [39:0]        rsp_recovered_total,
   output logic [23:0]        rsp_extra_range,
   output logic signed [14:0] rsp_last_batt_temp
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DT, ST_ACC, ST_SETUP, ST_MUL, ST_DIV, ST_POST, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      J_EFF, J_AVG, J_EMA1, J_EMA2, J_REGEN, J_COAST, J_CAPM, J_SOC, J_RANGE,
      J_EXTRA, J_DIST
   } job_type;

   state_type state_ff;
   job_type   job_ff;

   logic [15:0] warm_ff;
   logic [17:0] ref_ff;
   logic [15:0] alpha_ff;
   logic [19:0] cap_ff;

   logic [23:0]        ts_ff;
   logic [14:0]        speed_ff;
   logic               coast_ff;
   logic signed [17:0] cur_ff;
   logic signed [20:0] einst_ff;
   logic [19:0]        ke_ff;
   logic [19:0]        rec_ff;
   logic signed [14:0] temp_ff;

   logic [23:0]        last_ts_ff;
   logic [38:0]        dtp_ff;
   logic [47:0]        sts_ff;
   logic [23:0]        cs_ff;
   logic [47:0]        chg_ff;
   logic [47:0]        dis_ff;
   logic signed [47:0] esum_ff;
   logic [47:0]        kes_ff;
   logic [39:0]        recs_ff;
   logic [17:0]        ema_ff;

   logic [13:0] eff_ff;
   logic [17:0] avg_ff;
   logic [15:0] regen_ff;
   logic [13:0] coastp_ff;
   logic [13:0] soc_ff;
   logic [23:0] range_ff;
   logic [23:0] extra_ff;
   logic [31:0] dist_ff;
   logic [33:0] emat_ff;
   logic [29:0] capm_ff;

   logic rsp_valid_ff;

   logic [23:0]        dt;
   logic [48:0]        total;
   logic signed [49:0] num;
   logic [17:0]        mag;
   logic [48:0]        sum_sts, sum_chg, sum_dis, sum_kes;
   logic [40:0]        sum_recs;
   logic signed [48:0] sum_e;
   logic [35:0]        ema_sum;
   logic [19:0]        ema_new;
   logic               warmup;

   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [DIV_D_W-1:0] op_d;
   logic               use_div, skip;
   logic               mul_start, mul_busy, mul_done;
   logic               div_start, div_busy, div_done;
   logic [MUL_A_W-1:0] mul_p;
   logic [DIV_N_W-1:0] div_q;

   assign dt     = (ts_ff > last_ts_ff) ? ts_ff - last_ts_ff : 24'd0;
   assign total  = {1'b0, chg_ff} + {1'b0, dis_ff};
   assign num    = $signed({20'd0, capm_ff}) - 50'(esum_ff);
   assign mag    = 18'(-cur_ff);
   assign warmup = ts_ff < {8'd0, warm_ff};

   assign sum_sts  = {1'b0, sts_ff} + {10'd0, dtp_ff};
   assign sum_chg  = {1'b0, chg_ff} + {31'd0, mag};
   assign sum_dis  = {1'b0, dis_ff} + {31'd0, cur_ff};
   assign sum_kes  = {1'b0, kes_ff} + {29'd0, ke_ff};
   assign sum_recs = {1'b0, recs_ff} + {21'd0, rec_ff};
   assign sum_e    = {esum_ff[47], esum_ff} + 49'(einst_ff);
   assign ema_sum  = {2'd0, emat_ff} + {2'd0, mul_p[33:0]} + 36'd32768;
   assign ema_new  = ema_sum[35:16];

   always_comb begin
      op_a    = '0;
      op_b    = '0;
      op_d    = '0;
      use_div = 1'b0;
      skip    = 1'b0;
      case (job_ff)
         J_EFF: begin
            op_a    = MUL_A_W'(chg_ff);
            op_b    = MUL_B_W'(10000);
            op_d    = DIV_D_W'(total);
            use_div = 1'b1;
            skip    = (total == '0);
         end
         J_AVG: begin
            op_a    = MUL_A_W'(esum_ff[46:0]);
            op_b    = MUL_B_W'(36000);
            op_d    = DIV_D_W'(sts_ff);
            use_div = 1'b1;
            skip    = !(sts_ff > 48'd3600 && !esum_ff[47] && esum_ff != '0);
         end
         J_EMA1: begin
            op_a = MUL_A_W'(avg_ff);
            op_b = MUL_B_W'(alpha_ff);
            skip = warmup || (speed_ff <= 15'd100);
         end
         J_EMA2: begin
            op_a = MUL_A_W'(ema_ff);
            op_b = MUL_B_W'(17'd65536 - {1'b0, alpha_ff});
         end
         J_REGEN: begin
            op_a    = MUL_A_W'(recs_ff);
            op_b    = MUL_B_W'(10000);
            op_d    = DIV_D_W'(kes_ff);
            use_div = 1'b1;
            skip    = (kes_ff == '0);
         end
         J_COAST: begin
            op_a    = MUL_A_W'(cs_ff);
            op_b    = MUL_B_W'(10000);
            op_d    = DIV_D_W'(ts_ff);
            use_div = 1'b1;
            skip    = (ts_ff == '0);
         end
         J_CAPM: begin
            op_a = MUL_A_W'(cap_ff);
            op_b = MUL_B_W'(1000);
         end
         J_SOC: begin
            op_a    = MUL_A_W'(num[47:0]);
            op_b    = MUL_B_W'(10000);
            op_d    = DIV_D_W'(capm_ff);
            use_div = 1'b1;
            skip    = (capm_ff == '0) || num[49] || (num == '0);
         end
         J_RANGE: begin
            op_a    = MUL_A_W'(soc_ff);
            op_b    = MUL_B_W'(cap_ff);
            op_d    = DIV_D_W'(ema_ff);
            use_div = 1'b1;
            skip    = (capm_ff == '0) || (ema_ff == '0);
         end
         J_EXTRA: begin
            op_a    = MUL_A_W'(recs_ff);
            op_b    = MUL_B_W'(10);
            op_d    = DIV_D_W'(avg_ff);
            use_div = 1'b1;
            skip    = (avg_ff == '0);
         end
         J_DIST: begin
            op_a    = MUL_A_W'(sts_ff);
            op_b    = MUL_B_W'(1);
            op_d    = DIV_D_W'(360);
            use_div = 1'b1;
         end
         default: begin
            skip = 1'b1;
         end
      endcase
   end

   assign mul_start = (state_ff == ST_SETUP) && !skip;
   assign div_start = (state_ff == ST_MUL) && mul_done && use_div;

   tma_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_p)
   );

   tma_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_N_W'(mul_p)),
      .divisor  (op_d),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= J_EFF;
         rsp_valid_ff <= 1'b0;
         warm_ff      <= RST_EMA_WARMUP;
         ref_ff       <= RST_REF_EPK;
         alpha_ff     <= RST_EMA_ALPHA;
         cap_ff       <= RST_BATT_CAP;
         last_ts_ff   <= '0;
         sts_ff       <= '0;
         cs_ff        <= '0;
         chg_ff       <= '0;
         dis_ff       <= '0;
         esum_ff      <= '0;
         kes_ff       <= '0;
         recs_ff      <= '0;
         ema_ff       <= '0;
         temp_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_EMA_WARMUP: warm_ff  <= csr_wdata[15:0];
               CSR_REF_EPK:    ref_ff   <= csr_wdata[17:0];
               CSR_EMA_ALPHA:  alpha_ff <= csr_wdata[15:0];
               CSR_BATT_CAP:   cap_ff   <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  ts_ff    <= req_timestamp_sec;
                  speed_ff <= req_speed;
                  coast_ff <= req_coasting;
                  cur_ff   <= req_current;
                  einst_ff <= req_energy_inst;
                  ke_ff    <= req_ke_lost;
                  rec_ff   <= req_energy_recovered;
                  temp_ff  <= req_batt_temp;
                  state_ff <= ST_DT;
               end
            end
            ST_DT: begin
               dtp_ff     <= 39'({24'd0, speed_ff} * {15'd0, dt});
               last_ts_ff <= ts_ff;
               state_ff   <= ST_ACC;
            end
            ST_ACC: begin
               sts_ff <= sum_sts[48] ? MAX48 : sum_sts[47:0];
               if (coast_ff && cs_ff != MAX24) begin
                  cs_ff <= cs_ff + 24'd1;
               end
               if (cur_ff[17]) begin
                  chg_ff <= sum_chg[48] ? MAX48 : sum_chg[47:0];
               end else begin
                  dis_ff <= sum_dis[48] ? MAX48 : sum_dis[47:0];
               end
               if (sum_e[48] != sum_e[47]) begin
                  esum_ff <= sum_e[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  esum_ff <= sum_e[47:0];
               end
               kes_ff   <= sum_kes[48] ? MAX48 : sum_kes[47:0];
               recs_ff  <= sum_recs[40] ? MAX40 : sum_recs[39:0];
               job_ff   <= J_EFF;
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               if (skip) begin
                  case (job_ff)
                     J_EFF:   eff_ff    <= '0;
                     J_AVG:   avg_ff    <= '0;
                     J_EMA1: begin
                        if (warmup || ema_ff < ref_ff) begin
                           ema_ff <= ref_ff;
                        end
                     end
                     J_REGEN: regen_ff  <= '0;
                     J_COAST: coastp_ff <= '0;
                     J_SOC:   soc_ff    <= '0;
                     J_RANGE: range_ff  <= '0;
                     J_EXTRA: extra_ff  <= '0;
                     default: ;
                  endcase
                  if (job_ff == J_DIST) begin
                     state_ff <= ST_DONE;
                  end else if (job_ff == J_EMA1) begin
                     job_ff <= J_REGEN;
                  end else begin
                     job_ff <= job_type'(job_ff + 4'd1);
                  end
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  state_ff <= use_div ? ST_DIV : ST_POST;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_POST;
               end
            end
            ST_POST: begin
               case (job_ff)
                  J_EFF:  eff_ff <= div_q[13:0];
                  J_AVG:  avg_ff <= (div_q > 64'd200000) ? 18'd0 : div_q[17:0];
                  J_EMA1: emat_ff <= mul_p[33:0];
                  J_EMA2: begin
                     ema_ff <= (ema_new < {2'd0, ref_ff}) ? ref_ff : ema_new[17:0];
                  end
                  J_REGEN: regen_ff <= (div_q > 64'd65535) ? 16'hFFFF : div_q[15:0];
                  J_COAST: coastp_ff <= (div_q > 64'd10000) ? 14'd10000 : div_q[13:0];
                  J_CAPM:  capm_ff <= mul_p[29:0];
                  J_SOC:   soc_ff <= (div_q > 64'd10000) ? 14'd10000 : div_q[13:0];
                  J_RANGE: range_ff <= (div_q > 64'(MAX24)) ? MAX24 : div_q[23:0];
                  J_EXTRA: extra_ff <= (div_q > 64'(MAX24)) ? MAX24 : div_q[23:0];
                  J_DIST:  dist_ff <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                  default: ;
               endcase
               if (job_ff == J_DIST) begin
                  state_ff <= ST_DONE;
               end else begin
                  job_ff   <= job_type'(job_ff + 4'd1);
                  state_ff <= ST_SETUP;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_distance_m        <= dist_ff;
                  rsp_batt_eff_pct      <= eff_ff;
                  rsp_avg_energy_per_km <= avg_ff;
                  rsp_ema_energy_per_km <= ema_ff;
                  rsp_regen_eff_pct     <= regen_ff;
                  rsp_coasting_pct      <= coastp_ff;
                  rsp_soc_pct           <= soc_ff;
                  rsp_range_left        <= range_ff;
                  rsp_recovered_total   <= recs_ff;
                  rsp_extra_range       <= extra_ff;
                  rsp_last_batt_temp    <= temp_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_busy && div_busy))
      else $error("multiplier and divider busy together");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DT)
      else $error("accepted transaction did not start the sequencer");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_batt_eff_pct <= 14'd10000 && rsp_soc_pct <= 14'd10000 &&
                    rsp_coasting_pct <= 14'd10000)
      else $error("percentage out of range");

   a_ema_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POST && job_ff == J_EMA2 |=> ema_ff >= ref_ff)
      else $error("smoothed value below reference");

endmodule
